/* sv/fir_pkg.sv */
// shared widths, sizes and control types for the direct-form fir filter
// no dependencies; used by fir_mac and fir_filter_direct_form
package fir_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = 35;
  localparam int NUM_COEFS = 8;
  localparam int CFG_AW    = 3;
  localparam int TAPS_DEF  = 8;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

endpackage

/* sv/fir_filter_direct_form.sv */
// Direct-form FIR filter with TAPS taps (1 to 8) and signed Q1.15 coefficients
// written through cfg_we/cfg_addr/cfg_wdata; coefficient k weights the sample
// k steps back. Each accepted 16-bit sample yields one full-precision 35-bit
// result. One multiplier is shared across the taps, and the block takes no new
// sample until it is through with the last one: it stores the sample, runs one
// multiply per tap, finishes the accumulate and then, once the output register
// is free, loads it. A finished result waits in the output register while the
// next item is already accepted. History resets to zeros.
// depends on fir_pkg and fir_mac
module fir_filter_direct_form #(
  parameter int TAPS = fir_pkg::TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fir_pkg::ACC_W-1:0]     out_filtered,
  input  logic                                 cfg_we,
  input  logic [fir_pkg::CFG_AW-1:0]           cfg_addr,
  input  logic [fir_pkg::COEF_W-1:0]           cfg_wdata
);

  localparam int KW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [KW-1:0] LAST = KW'(TAPS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [KW-1:0] wp_r, wp_nxt;
  logic [KW-1:0] rd_r, rd_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic signed [fir_pkg::ACC_W-1:0] out_data_r;

  logic signed [fir_pkg::COEF_W-1:0]   coef_r [fir_pkg::NUM_COEFS];
  logic signed [fir_pkg::SAMPLE_W-1:0] hist_r [TAPS];

  logic                              accept;
  logic                              load_out;
  fir_pkg::mac_ctrl_t                mac_ctrl;
  logic signed [fir_pkg::ACC_W-1:0]  acc;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rd_nxt        = rd_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    mac_ctrl.clr  = 1'b0;
    mac_ctrl.en   = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // write position counts down and wraps
          wp_nxt       = (wp_r == '0) ? LAST : wp_r - KW'(1);
          rd_nxt       = wp_nxt;
          k_nxt        = '0;
          mac_ctrl.clr = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      ST_RUN: begin
        mac_ctrl.en = 1'b1;
        rd_nxt      = (rd_r == LAST) ? '0 : rd_r + KW'(1);
        k_nxt       = k_r + KW'(1);
        if (k_r == LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rd_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rd_r        <= rd_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fir_pkg::NUM_COEFS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we) begin
      coef_r[cfg_addr] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        hist_r[i] <= '0;
      end
    end else if (accept) begin
      hist_r[wp_nxt] <= in_sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= acc;
    end
  end

  fir_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .sample (hist_r[rd_r]),
    .coef   (coef_r[fir_pkg::CFG_AW'(k_r)]),
    .acc    (acc)
  );

  assign out_valid    = out_valid_r;
  assign out_filtered = out_data_r;

endmodule

/* sv/fir_mac.sv */
// shared multiply-accumulate unit: registered product, then 35-bit accumulate
// depends on fir_pkg
module fir_mac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fir_pkg::mac_ctrl_t                     ctrl,
  input  logic signed [fir_pkg::SAMPLE_W-1:0]    sample,
  input  logic signed [fir_pkg::COEF_W-1:0]      coef,
  output logic signed [fir_pkg::ACC_W-1:0]       acc
);

  logic signed [fir_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic                              pv_r;
  logic signed [fir_pkg::ACC_W-1:0]  acc_r, acc_nxt;

  always_comb begin
    prod_nxt = sample * coef;
    acc_nxt  = acc_r;
    if (ctrl.clr) begin
      acc_nxt = '0;
    end else if (pv_r) begin
      acc_nxt = acc_r + {{(fir_pkg::ACC_W - fir_pkg::PROD_W){prod_r[fir_pkg::PROD_W-1]}},
                         prod_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctrl.en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule
